// ===== hdl/sspe_pkg.sv =====
`timescale 1ns / 1ps

package sspe_pkg;

	localparam int SYM_W = 7;
	localparam int BYTE_W = 8;
	localparam int NUM_SLOTS = 7;
	localparam int SLOT_IDX_W = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] FRAME_START = 8'hF0;
	localparam logic [BYTE_W-1:0] MAKER_ID = 8'h7D;
	localparam logic [BYTE_W-1:0] FRAME_END = 8'hF7;

	localparam logic [2:0] GROUP_LAST = 3'd7;

	// Positions of the bytes that one transaction can cause, in send order.
	localparam logic [SLOT_IDX_W-1:0] SLOT_START = 3'd0;
	localparam logic [SLOT_IDX_W-1:0] SLOT_MAKER = 3'd1;
	localparam logic [SLOT_IDX_W-1:0] SLOT_TYPE = 3'd2;
	localparam logic [SLOT_IDX_W-1:0] SLOT_SYM = 3'd3;
	localparam logic [SLOT_IDX_W-1:0] SLOT_EXTRA = 3'd4;
	localparam logic [SLOT_IDX_W-1:0] SLOT_SUM = 3'd5;
	localparam logic [SLOT_IDX_W-1:0] SLOT_END = 3'd6;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [SYM_W-1:0] type_byte;
		logic [SYM_W-1:0] sym;
		logic [SYM_W-1:0] extra;
		logic [SYM_W-1:0] sum;
	} cmd_t;

endpackage

// ===== hdl/sspe_ifs.sv =====
`timescale 1ns / 1ps

interface sspe_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic is_last;
	modport source(output valid, output data_byte, output is_last, input ready);
	modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

interface sspe_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic end_of_run;
	modport source(output valid, output out_byte, output end_of_run, input ready);
	modport sink(input valid, input out_byte, input end_of_run, output ready);
endinterface

// ===== hdl/sspe_front.sv =====
`timescale 1ns / 1ps

module sspe_front (
	input logic clk,
	input logic arst_n,
	sspe_in_if.sink payload,
	input logic [sspe_pkg::SYM_W-1:0] type_byte,
	input logic q_full,
	output logic q_push,
	output sspe_pkg::cmd_t q_cmd
);

	logic [sspe_pkg::SYM_W-1:0] carry_q;
	logic [2:0] count_q;
	logic [sspe_pkg::SYM_W-1:0] sum_q;
	logic in_frame_q;

	logic [2*sspe_pkg::SYM_W-1:0] acc;
	logic [sspe_pkg::SYM_W-1:0] sym;
	logic [sspe_pkg::SYM_W-1:0] rest;
	logic [2:0] count_inc;
	logic seventh;
	logic [sspe_pkg::SYM_W-1:0] sum_new;

	assign payload.ready = !q_full;
	assign q_push = payload.valid && !q_full;

	always_comb begin
		acc = {{sspe_pkg::SYM_W{1'b0}}, carry_q}
			| ({{(sspe_pkg::SYM_W-1){1'b0}}, payload.data_byte} << count_q);
		sym = acc[sspe_pkg::SYM_W-1:0];
		rest = acc[2*sspe_pkg::SYM_W-1:sspe_pkg::SYM_W];
		count_inc = count_q + 3'd1;
		seventh = (count_inc == sspe_pkg::GROUP_LAST);
		sum_new = sum_q + sym;

		q_cmd = '0;
		q_cmd.type_byte = type_byte;
		q_cmd.sym = sym;
		q_cmd.extra = rest;
		q_cmd.sum = sum_new;
		q_cmd.mask[sspe_pkg::SLOT_START] = !in_frame_q;
		q_cmd.mask[sspe_pkg::SLOT_MAKER] = !in_frame_q;
		q_cmd.mask[sspe_pkg::SLOT_TYPE] = !in_frame_q;
		q_cmd.mask[sspe_pkg::SLOT_SYM] = 1'b1;
		// A group's carry symbol and a frame's leftover symbol share one slot:
		// after a full group nothing is left over.
		q_cmd.mask[sspe_pkg::SLOT_EXTRA] = seventh || payload.is_last;
		q_cmd.mask[sspe_pkg::SLOT_SUM] = payload.is_last;
		q_cmd.mask[sspe_pkg::SLOT_END] = payload.is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			in_frame_q <= 1'b0;
		end else if (q_push) begin
			if (payload.is_last) begin
				carry_q <= '0;
				count_q <= '0;
				sum_q <= '0;
				in_frame_q <= 1'b0;
			end else begin
				carry_q <= seventh ? '0 : rest;
				count_q <= seventh ? 3'd0 : count_inc;
				sum_q <= sum_new;
				in_frame_q <= 1'b1;
			end
		end
	end

	property p_last_closes;
		@(posedge clk) disable iff (!arst_n)
		(q_push && payload.is_last) |=> (!in_frame_q && count_q == 3'd0 && sum_q == '0);
	endproperty
	a_last_closes: assert property (p_last_closes) else $error("frame not closed");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n)
		count_q != sspe_pkg::GROUP_LAST;
	endproperty
	a_count_range: assert property (p_count_range) else $error("group count overran");

	property p_open_frame;
		@(posedge clk) disable iff (!arst_n)
		(q_push && !payload.is_last) |=> in_frame_q;
	endproperty
	a_open_frame: assert property (p_open_frame) else $error("frame not opened");

endmodule

// ===== hdl/sspe_queue.sv =====
`timescale 1ns / 1ps

module sspe_queue #(
	parameter int DEPTH = sspe_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sspe_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output sspe_pkg::cmd_t head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	sspe_pkg::cmd_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_pop;

	assign full = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_cmd = entries_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/sspe_back.sv =====
`timescale 1ns / 1ps

module sspe_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input sspe_pkg::cmd_t head_cmd,
	output logic pop,
	sspe_out_if.source frame
);

	logic [sspe_pkg::NUM_SLOTS-1:0] mask_q;
	sspe_pkg::cmd_t cmd_q;
	logic out_valid_q;
	logic [sspe_pkg::BYTE_W-1:0] out_byte_q;
	logic out_end_q;

	logic [sspe_pkg::NUM_SLOTS-1:0] low_bit;
	logic [sspe_pkg::NUM_SLOTS-1:0] mask_rest;
	logic [sspe_pkg::SLOT_IDX_W-1:0] slot;
	logic [sspe_pkg::BYTE_W-1:0] slot_byte;
	logic can_emit;
	logic emit;

	assign can_emit = !out_valid_q || frame.ready;
	assign emit = can_emit && (mask_q != '0);
	assign mask_rest = mask_q & ~low_bit;
	assign pop = head_valid && ((mask_q == '0) || (emit && (mask_rest == '0)));

	always_comb begin
		low_bit = '0;
		slot = '0;
		for (int i = sspe_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_bit = '0;
				low_bit[i] = 1'b1;
				slot = sspe_pkg::SLOT_IDX_W'(i);
			end
		end
	end

	always_comb begin
		case (slot)
			sspe_pkg::SLOT_START: slot_byte = sspe_pkg::FRAME_START;
			sspe_pkg::SLOT_MAKER: slot_byte = sspe_pkg::MAKER_ID;
			sspe_pkg::SLOT_TYPE: slot_byte = {1'b0, cmd_q.type_byte};
			sspe_pkg::SLOT_SYM: slot_byte = {1'b0, cmd_q.sym};
			sspe_pkg::SLOT_EXTRA: slot_byte = {1'b0, cmd_q.extra};
			sspe_pkg::SLOT_SUM: slot_byte = {1'b0, cmd_q.sum};
			sspe_pkg::SLOT_END: slot_byte = sspe_pkg::FRAME_END;
			default: slot_byte = sspe_pkg::FRAME_END;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			out_byte_q <= slot_byte;
			out_end_q <= (mask_rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= head_cmd.mask;
			end else if (emit) begin
				mask_q <= mask_rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (can_emit) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign frame.valid = out_valid_q;
	assign frame.out_byte = out_byte_q;
	assign frame.end_of_run = out_end_q;

	property p_load_has_symbol;
		@(posedge clk) disable iff (!arst_n)
		pop |=> mask_q[sspe_pkg::SLOT_SYM];
	endproperty
	a_load_has_symbol: assert property (p_load_has_symbol) else $error("empty command loaded");

	property p_mid_run_continues;
		@(posedge clk) disable iff (!arst_n)
		(emit && (mask_rest != '0)) |=> (mask_q != '0);
	endproperty
	a_mid_run_continues: assert property (p_mid_run_continues) else $error("run cut short");

	property p_single_slot;
		@(posedge clk) disable iff (!arst_n)
		$onehot0(low_bit) && ((mask_q == '0) || $onehot(low_bit));
	endproperty
	a_single_slot: assert property (p_single_slot) else $error("slot select broken");

endmodule

// ===== hdl/sysex_seven_bit_pack_encoder_core.sv =====
`timescale 1ns / 1ps

// Seven-bit system-exclusive frame encoder.
// The payload channel takes one transaction per payload byte, with is_last set
// on the final byte of a frame. The frame channel gives one transaction per
// frame byte; end_of_run marks the last byte caused by one payload byte.
// A frame opens with 0xF0, 0x7D and the type byte from cfg_wr_data, which is
// written whenever cfg_wr_en is high and should only change between frames.
// The front stage packs each byte into symbols and queues a command in the
// same cycle it is accepted; the back stage sends one frame byte per cycle
// while the receiver is ready. A payload byte causes one to seven frame
// bytes, usually one or two; the output port sets the rate. A command passes
// through the queue and the back stage's command register before its first
// frame byte enters the output register. The front keeps accepting until the
// command queue is full, so a stalled receiver holds the output register and
// backs up into the payload channel after the queue fills. Reset clears the
// packing state, the queue, the output valid flag and the type byte to zero.
module sysex_seven_bit_pack_encoder_core #(
	parameter int QUEUE_DEPTH = sspe_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	sspe_in_if.sink payload,
	sspe_out_if.source frame,
	input logic cfg_wr_en,
	input logic [sspe_pkg::SYM_W-1:0] cfg_wr_data
);

	logic [sspe_pkg::SYM_W-1:0] type_byte_q;
	logic q_full;
	logic q_push;
	sspe_pkg::cmd_t q_cmd;
	logic q_pop;
	logic head_valid;
	sspe_pkg::cmd_t head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_byte_q <= '0;
		end else if (cfg_wr_en) begin
			type_byte_q <= cfg_wr_data;
		end
	end

	sspe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.payload(payload),
		.type_byte(type_byte_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	sspe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	sspe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(q_pop),
		.frame(frame)
	);

endmodule
